>>> hdl/mvs_pkg.sv
`default_nettype none

package mvs_pkg;

  localparam int SampleBits = 16;
  localparam int CntW       = 25;
  localparam int MaxVoxels  = 16777216;
  localparam int SumW       = 40;
  localparam int SqW        = 31;
  localparam int SumSqW     = 56;
  localparam int AccW       = 80;
  localparam int RadW       = 102;
  localparam int RootW      = 51;
  localparam int RemW       = 54;
  localparam int NumW       = 52;
  localparam int DivW       = CntW + 1;
  localparam int MeanW      = 24;
  localparam int SdW        = 24;
  localparam int StepW      = 6;

  localparam logic [StepW-1:0] MulaLast = StepW'(CntW - 1);
  localparam logic [StepW-1:0] MulbLast = StepW'(SumW - 1);
  localparam logic [StepW-1:0] SqrtLast = StepW'(RootW - 1);
  localparam logic [StepW-1:0] DivLast  = StepW'(NumW - 1);

  localparam logic signed [SampleBits-1:0] SampleMax = {1'b0, {(SampleBits-1){1'b1}}};
  localparam logic signed [SampleBits-1:0] SampleMin = {1'b1, {(SampleBits-1){1'b0}}};

  localparam logic [MeanW-1:0] MeanMax    = {1'b0, {(MeanW-1){1'b1}}};
  localparam logic [MeanW-1:0] MeanMin    = {1'b1, {(MeanW-1){1'b0}}};
  localparam logic [SdW-1:0]   SdMax      = {SdW{1'b1}};

endpackage

`default_nettype wire

>>> hdl/mvs_if.sv
`default_nettype none

interface mvs_sample_if;
  import mvs_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;
  logic                         sample_finite;
  logic                         in_mask;
  logic                         end_of_volume;

  modport source (output valid, sample, sample_finite, in_mask, end_of_volume, input ready);
  modport sink   (input valid, sample, sample_finite, in_mask, end_of_volume, output ready);
endinterface

interface mvs_result_if;
  import mvs_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [MeanW-1:0]      mean_value;
  logic        [SdW-1:0]        std_dev;
  logic signed [SampleBits-1:0] min_value;
  logic signed [SampleBits-1:0] max_value;
  logic        [CntW-1:0]       voxel_count;
  logic                         no_voxels;

  modport source (output valid, mean_value, std_dev, min_value, max_value, voxel_count,
                  no_voxels, input ready);
  modport sink   (input valid, mean_value, std_dev, min_value, max_value, voxel_count,
                  no_voxels, output ready);
endinterface

`default_nettype wire

>>> hdl/masked_volume_statistics.sv
`default_nettype none

// Masked volume statistics. Each sample transfer is counted when it is finite and, with
// mask_enable set, inside the mask, while the count is below MaxVoxels; counted samples
// update a running sum, sum of squares, minimum, maximum and count. A sample goes through
// accept, sum and sum of squares before the next is taken; the sample carrying end_of_volume
// then starts a finishing sequence in which one shared 80-bit add/subtract unit does every
// bit step: the mean divide (52 steps), the two shift-add products n*sumsq (25) and sum^2
// (40), the square root (51) and the deviation divide (52). An empty volume goes from the
// check straight to the result. The result sits in an output register, so the next volume
// can start while it waits to be taken; a following end of volume waits for that register.
// Mean and deviation carry 8 fractional bits and are rounded to nearest.
module masked_volume_statistics (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  mvs_sample_if.sink         smp_i,
  mvs_result_if.source       res_o
);
  import mvs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM, ST_SQS, ST_CHECK, ST_MAG, ST_NUMM, ST_DIVM, ST_STM,
    ST_MULA, ST_MULB, ST_SUBT, ST_SQRT, ST_NUMS, ST_DIVS, ST_DONE
  } state_e;

  state_e                       state_q, state_d;
  logic                         mask_en_q;
  logic                         res_valid_q, res_valid_d;
  logic signed [SumW-1:0]       sum_q, sum_d;
  logic        [SumSqW-1:0]     sumsq_q, sumsq_d;
  logic signed [SampleBits-1:0] min_q, min_d;
  logic signed [SampleBits-1:0] max_q, max_d;
  logic        [CntW-1:0]       count_q, count_d;

  logic signed [SampleBits-1:0] s_q, s_d;
  logic                         take_q, take_d;
  logic                         eov_q, eov_d;
  logic        [SqW-1:0]        sq_q, sq_d;
  logic        [SumW-1:0]       mag_q, mag_d;
  logic        [NumW-1:0]       num_q, num_d;
  logic        [RemW-1:0]       rem_q, rem_d;
  logic        [AccW-1:0]       prod_q, prod_d;
  logic        [AccW-1:0]       acc_q, acc_d;
  logic        [RadW-1:0]       rad_q, rad_d;
  logic        [RootW-1:0]      root_q, root_d;
  logic        [MeanW-1:0]      mean_q, mean_d;
  logic                         empty_q, empty_d;
  logic        [StepW-1:0]      step_q, step_d;

  logic signed [MeanW-1:0]      res_mean_q, res_mean_d;
  logic        [SdW-1:0]        res_sd_q, res_sd_d;
  logic signed [SampleBits-1:0] res_min_q, res_min_d;
  logic signed [SampleBits-1:0] res_max_q, res_max_d;
  logic        [CntW-1:0]       res_cnt_q, res_cnt_d;
  logic                         res_empty_q, res_empty_d;

  // shared add/subtract unit
  logic        [AccW-1:0]       u_a, u_b;
  logic                         u_sub;
  logic        [AccW:0]         u_tot;
  logic        [AccW-1:0]       u_sum;
  logic                         u_carry;

  logic signed [2*SampleBits-1:0] sq_full;
  logic        [DivW:0]         div_shift;
  logic        [RemW-1:0]       sqrt_shift;
  logic        [SdW-1:0]        sd_sat;
  logic                         smp_xfer;
  logic                         res_free;

  assign sq_full    = s_q * s_q;
  assign div_shift  = {rem_q[DivW-1:0], num_q[NumW-1]};
  assign sqrt_shift = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign sd_sat     = (|num_q[NumW-1:SdW]) ? SdMax : num_q[SdW-1:0];
  assign smp_xfer   = smp_i.valid && smp_i.ready;
  assign res_free   = !res_valid_q || res_o.ready;

  assign u_tot   = {1'b0, u_a} + {1'b0, (u_sub ? ~u_b : u_b)} + (AccW+1)'(u_sub);
  assign u_sum   = u_tot[AccW-1:0];
  assign u_carry = u_tot[AccW];

  always_comb begin
    u_a   = '0;
    u_b   = '0;
    u_sub = 1'b0;
    unique case (state_q)
      ST_SUM: begin
        u_a = AccW'(sum_q);
        u_b = AccW'(s_q);
      end
      ST_SQS: begin
        u_a = AccW'(sumsq_q);
        u_b = AccW'(sq_q);
      end
      ST_MAG: begin
        u_b   = AccW'(sum_q);
        u_sub = sum_q[SumW-1];
      end
      ST_NUMM: begin
        u_a = AccW'({mag_q, 9'd0});
        u_b = AccW'(count_q);
      end
      ST_DIVM, ST_DIVS: begin
        u_a   = AccW'(div_shift);
        u_b   = AccW'({count_q, 1'b0});
        u_sub = 1'b1;
      end
      ST_MULA: begin
        u_a = {prod_q[AccW-2:0], 1'b0};
        u_b = count_q[step_q[4:0]] ? AccW'(sumsq_q) : '0;
      end
      ST_MULB: begin
        u_a = {acc_q[AccW-2:0], 1'b0};
        u_b = mag_q[step_q] ? AccW'(mag_q) : '0;
      end
      ST_SUBT: begin
        u_a   = prod_q;
        u_b   = acc_q;
        u_sub = 1'b1;
      end
      ST_SQRT: begin
        u_a   = AccW'(sqrt_shift);
        u_b   = AccW'({root_q, 2'b01});
        u_sub = 1'b1;
      end
      ST_NUMS: begin
        u_a = AccW'(root_q);
        u_b = AccW'(count_q);
      end
      default: begin
        u_a   = '0;
        u_b   = '0;
        u_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    res_valid_d = res_valid_q;
    sum_d       = sum_q;
    sumsq_d     = sumsq_q;
    min_d       = min_q;
    max_d       = max_q;
    count_d     = count_q;
    s_d         = s_q;
    take_d      = take_q;
    eov_d       = eov_q;
    sq_d        = sq_q;
    mag_d       = mag_q;
    num_d       = num_q;
    rem_d       = rem_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    rad_d       = rad_q;
    root_d      = root_q;
    mean_d      = mean_q;
    empty_d     = empty_q;
    step_d      = step_q;
    res_mean_d  = res_mean_q;
    res_sd_d    = res_sd_q;
    res_min_d   = res_min_q;
    res_max_d   = res_max_q;
    res_cnt_d   = res_cnt_q;
    res_empty_d = res_empty_q;

    if (res_valid_q && res_o.ready) begin
      res_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (smp_xfer) begin
          s_d     = smp_i.sample;
          take_d  = smp_i.sample_finite && (!mask_en_q || smp_i.in_mask) &&
                    (count_q < CntW'(MaxVoxels));
          eov_d   = smp_i.end_of_volume;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        sq_d = sq_full[SqW-1:0];
        if (take_q) begin
          sum_d = u_sum[SumW-1:0];
        end
        state_d = ST_SQS;
      end
      ST_SQS: begin
        if (take_q) begin
          sumsq_d = u_sum[SumSqW-1:0];
          count_d = count_q + CntW'(1);
          if (s_q < min_q) begin
            min_d = s_q;
          end
          if (s_q > max_q) begin
            max_d = s_q;
          end
        end
        state_d = eov_q ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        empty_d = (count_q == '0);
        state_d = (count_q == '0) ? ST_DONE : ST_MAG;
      end
      ST_MAG: begin
        mag_d   = u_sum[SumW-1:0];
        state_d = ST_NUMM;
      end
      ST_NUMM: begin
        num_d   = u_sum[NumW-1:0];
        rem_d   = '0;
        step_d  = DivLast;
        state_d = ST_DIVM;
      end
      ST_DIVM, ST_DIVS: begin
        rem_d  = u_carry ? u_sum[RemW-1:0] : RemW'(div_shift);
        num_d  = {num_q[NumW-2:0], u_carry};
        step_d = step_q - StepW'(1);
        if (step_q == '0) begin
          state_d = (state_q == ST_DIVM) ? ST_STM : ST_DONE;
        end
      end
      ST_STM: begin
        if (sum_q[SumW-1]) begin
          if ((|num_q[NumW-1:MeanW]) || (num_q[MeanW-1:0] > MeanMin)) begin
            mean_d = MeanMin;
          end else begin
            mean_d = -num_q[MeanW-1:0];
          end
        end else begin
          mean_d = (|num_q[NumW-1:MeanW-1]) ? MeanMax : num_q[MeanW-1:0];
        end
        prod_d  = '0;
        step_d  = MulaLast;
        state_d = ST_MULA;
      end
      ST_MULA: begin
        prod_d = u_sum;
        step_d = step_q - StepW'(1);
        if (step_q == '0) begin
          acc_d   = '0;
          step_d  = MulbLast;
          state_d = ST_MULB;
        end
      end
      ST_MULB: begin
        acc_d  = u_sum;
        step_d = step_q - StepW'(1);
        if (step_q == '0) begin
          state_d = ST_SUBT;
        end
      end
      ST_SUBT: begin
        rad_d   = u_carry ? {4'd0, u_sum, 18'd0} : '0;
        rem_d   = '0;
        root_d  = '0;
        step_d  = SqrtLast;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        rem_d  = u_carry ? u_sum[RemW-1:0] : sqrt_shift;
        root_d = {root_q[RootW-2:0], u_carry};
        rad_d  = {rad_q[RadW-3:0], 2'b00};
        step_d = step_q - StepW'(1);
        if (step_q == '0) begin
          state_d = ST_NUMS;
        end
      end
      ST_NUMS: begin
        num_d   = u_sum[NumW-1:0];
        rem_d   = '0;
        step_d  = DivLast;
        state_d = ST_DIVS;
      end
      ST_DONE: begin
        if (res_free) begin
          res_valid_d = 1'b1;
          res_empty_d = empty_q;
          res_mean_d  = empty_q ? '0 : mean_q;
          res_sd_d    = empty_q ? '0 : sd_sat;
          res_min_d   = empty_q ? '0 : min_q;
          res_max_d   = empty_q ? '0 : max_q;
          res_cnt_d   = count_q;
          sum_d       = '0;
          sumsq_d     = '0;
          count_d     = '0;
          min_d       = SampleMax;
          max_d       = SampleMin;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      mask_en_q   <= 1'b0;
      sum_q       <= '0;
      sumsq_q     <= '0;
      count_q     <= '0;
      min_q       <= SampleMax;
      max_q       <= SampleMin;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      sum_q       <= sum_d;
      sumsq_q     <= sumsq_d;
      count_q     <= count_d;
      min_q       <= min_d;
      max_q       <= max_d;
      if (cfg_we_i) begin
        mask_en_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q         <= s_d;
    take_q      <= take_d;
    eov_q       <= eov_d;
    sq_q        <= sq_d;
    mag_q       <= mag_d;
    num_q       <= num_d;
    rem_q       <= rem_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    rad_q       <= rad_d;
    root_q      <= root_d;
    mean_q      <= mean_d;
    empty_q     <= empty_d;
    step_q      <= step_d;
    res_mean_q  <= res_mean_d;
    res_sd_q    <= res_sd_d;
    res_min_q   <= res_min_d;
    res_max_q   <= res_max_d;
    res_cnt_q   <= res_cnt_d;
    res_empty_q <= res_empty_d;
  end

  assign smp_i.ready       = (state_q == ST_IDLE);
  assign res_o.valid       = res_valid_q;
  assign res_o.mean_value  = res_mean_q;
  assign res_o.std_dev     = res_sd_q;
  assign res_o.min_value   = res_min_q;
  assign res_o.max_value   = res_max_q;
  assign res_o.voxel_count = res_cnt_q;
  assign res_o.no_voxels   = res_empty_q;

endmodule

`default_nettype wire

>>> tb/tb_masked_volume_statistics.sv
`timescale 1ns / 1ps

module tb_masked_volume_statistics;
  import mvs_pkg::*;

  localparam int CycleLimit   = 1_000_000;
  localparam int SettleCycles = 300;
  localparam int HoldCycles   = 1500;

  typedef struct {
    logic signed [MeanW-1:0]      mean_value;
    logic        [SdW-1:0]        std_dev;
    logic signed [SampleBits-1:0] min_value;
    logic signed [SampleBits-1:0] max_value;
    logic        [CntW-1:0]       voxel_count;
    logic                         no_voxels;
  } volume_stats_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  mvs_sample_if smp_if ();
  mvs_result_if res_if ();

  masked_volume_statistics i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .smp_i      (smp_if),
    .res_o      (res_if)
  );

  logic                         mask_en   = 1'b0;
  logic signed [SumW-1:0]       acc_sum   = '0;
  logic        [SumSqW-1:0]     acc_sq    = '0;
  logic signed [SampleBits-1:0] acc_min   = SampleMax;
  logic signed [SampleBits-1:0] acc_max   = SampleMin;
  logic        [CntW-1:0]       acc_count = '0;

  volume_stats_t stats_q[$];
  volume_stats_t want_stats;
  int            error_count = 0;
  int            cycle_count = 0;
  int            hold_cycles = 0;
  bit            src_gaps    = 1'b1;
  bit            sink_stalls = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // accumulates one voxel, closes the volume on end_of_volume
  function automatic void tally_voxel(logic signed [SampleBits-1:0] s, logic finite,
                                      logic in_mask, logic eov);
    logic signed [31:0] sx;
    logic [127:0]       n, mag, q, a, b, d, root, t, sd;
    int                 i;
    volume_stats_t      r;
    sx = 32'(s);
    if (finite && (!mask_en || in_mask) && acc_count < CntW'(MaxVoxels)) begin
      acc_sum += SumW'(s);
      acc_sq  += SumSqW'(sx * sx);
      if (s < acc_min) acc_min = s;
      if (s > acc_max) acc_max = s;
      acc_count++;
    end
    if (!eov) return;
    r = '{default: '0};
    if (acc_count == 0) begin
      r.no_voxels = 1'b1;
    end else begin
      n   = 128'(acc_count);
      mag = (acc_sum < 0) ? 128'(-acc_sum) : 128'(acc_sum);
      q   = ((mag << 9) + n) / (n << 1);
      if (acc_sum < 0) begin
        r.mean_value = (q > 128'd8388608) ? MeanMin : MeanW'(-q);
      end else begin
        r.mean_value = (q > 128'd8388607) ? MeanMax : MeanW'(q);
      end
      a = n * 128'(acc_sq);
      b = mag * mag;
      d = (b <= a) ? ((a - b) << 18) : '0;
      root = '0;
      for (i = 50; i >= 0; i--) begin
        t = root | (128'd1 << i);
        if (t * t <= d) root = t;
      end
      sd = (root + n) / (n << 1);
      r.std_dev     = (sd > 128'(SdMax)) ? SdMax : SdW'(sd);
      r.min_value   = acc_min;
      r.max_value   = acc_max;
      r.voxel_count = acc_count;
    end
    stats_q.push_back(r);
    acc_sum   = '0;
    acc_sq    = '0;
    acc_min   = SampleMax;
    acc_max   = SampleMin;
    acc_count = '0;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (stats_q.size() == 0) begin
        report_mismatch("result transfer with no volume pending");
      end else begin
        want_stats = stats_q.pop_front();
        check_field("mean_value", 32'(res_if.mean_value), 32'(want_stats.mean_value));
        check_field("std_dev", 32'(res_if.std_dev), 32'(want_stats.std_dev));
        check_field("min_value", 32'(res_if.min_value), 32'(want_stats.min_value));
        check_field("max_value", 32'(res_if.max_value), 32'(want_stats.max_value));
        check_field("voxel_count", 32'(res_if.voxel_count), 32'(want_stats.voxel_count));
        check_field("no_voxels", 32'(res_if.no_voxels), 32'(want_stats.no_voxels));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d volumes pending", cycle_count, stats_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side: random stalls plus an optional long hold-off
  initial begin
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        res_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        res_if.ready <= !(sink_stalls && $urandom_range(99) < 33);
      end
    end
  end

  // entered and left right after a falling edge
  task automatic send_voxel(logic signed [SampleBits-1:0] s, logic finite, logic in_mask,
                            logic eov);
    while (src_gaps && $urandom_range(99) < 33) begin
      smp_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    smp_if.valid         <= 1'b1;
    smp_if.sample        <= s;
    smp_if.sample_finite <= finite;
    smp_if.in_mask       <= in_mask;
    smp_if.end_of_volume <= eov;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    tally_voxel(s, finite, in_mask, eov);
    @(negedge clk_i);
  endtask

  task automatic send_random_voxel(logic eov, int finite_pct);
    logic signed [SampleBits-1:0] s;
    s = SampleBits'($urandom);
    if ($urandom_range(7) == 0) s = $urandom_range(1) ? SampleMax : SampleMin;
    send_voxel(s, $urandom_range(99) < finite_pct, $urandom_range(99) < 70, eov);
  endtask

  task automatic send_random_volume(int len, int finite_pct);
    int k;
    for (k = 0; k < len; k++) send_random_voxel(k == len - 1, finite_pct);
  endtask

  task automatic drain_results();
    smp_if.valid <= 1'b0;
    while (stats_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_mask(logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mask_en = v;
  endtask

  task automatic test_empty_volumes();
    send_voxel(SampleMax, 1'b0, 1'b1, 1'b0);
    send_voxel(SampleMin, 1'b0, 1'b1, 1'b1);
    send_voxel(16'sd0, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_sample_extremes();
    send_voxel(SampleMax, 1'b1, 1'b0, 1'b1);
    send_voxel(SampleMin, 1'b1, 1'b0, 1'b1);
    send_voxel(SampleMin, 1'b1, 1'b1, 1'b0);
    send_voxel(SampleMax, 1'b1, 1'b1, 1'b1);
    // negative mean that needs rounding
    send_voxel(-16'sd1, 1'b1, 1'b0, 1'b0);
    send_voxel(16'sd0, 1'b1, 1'b0, 1'b0);
    send_voxel(16'sd0, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_mask_enable();
    drain_results();
    write_mask(1'b1);
    send_voxel(16'sd100, 1'b1, 1'b1, 1'b0);
    send_voxel(-16'sd7, 1'b1, 1'b0, 1'b0);
    send_voxel(16'sd3, 1'b1, 1'b1, 1'b0);
    send_voxel(16'sd20000, 1'b0, 1'b1, 1'b1);
    // everything outside the mask
    send_voxel(16'sd5, 1'b1, 1'b0, 1'b0);
    send_voxel(16'sd6, 1'b1, 1'b0, 1'b1);
    drain_results();
    write_mask(1'b0);
    send_voxel(16'sd5, 1'b1, 1'b0, 1'b0);
    send_voxel(16'sd6, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_backpressure();
    src_gaps    = 1'b0;
    hold_cycles = HoldCycles;
    repeat (5) send_random_volume($urandom_range(2, 6), 90);
    drain_results();
    src_gaps = 1'b1;
  endtask

  task automatic test_random_volumes();
    int  phase;
    int  phase_items;
    int  len;
    bit  quiet;
    for (phase = 0; phase < 6; phase++) begin
      drain_results();
      write_mask(phase == 0 ? 1'b1 : (phase == 1 ? 1'b0 : 1'($urandom_range(1))));
      quiet       = (phase == 3);
      src_gaps    = !quiet;
      sink_stalls = !quiet;
      phase_items = 0;
      while (phase_items < 145) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        send_random_volume(len, ($urandom_range(11) == 0) ? 0 : 88);
        phase_items += len;
      end
    end
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
  endtask

  initial begin
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= 1'b0;
    smp_if.valid         <= 1'b0;
    smp_if.sample        <= '0;
    smp_if.sample_finite <= 1'b0;
    smp_if.in_mask       <= 1'b0;
    smp_if.end_of_volume <= 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_mask(1'b0);
    test_empty_volumes();
    test_sample_extremes();
    test_mask_enable();
    test_backpressure();
    test_random_volumes();
    drain_results();
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/mvs_pkg.sv
hdl/mvs_if.sv
hdl/masked_volume_statistics.sv
tb/tb_masked_volume_statistics.sv
